>>> rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants for the k-nearest-neighbor search
// Word formats, configuration register indexes and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

    // default sizes
    localparam int DEF_MAX_DIMS   = 64;
    localparam int DEF_MAX_K      = 16;
    localparam int DEF_MAX_POINTS = 1048576;
    localparam int DEF_COORD_BITS = 16;

    // fixed field widths
    localparam int COORD_W = 16;
    localparam int INDEX_W = 20;
    localparam int DIST_W  = 38;
    localparam int RANK_W  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int NDIMS_W    = 7;
    localparam int NCOUNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'd1;

    localparam logic [NDIMS_W-1:0]  NUM_DIMS_RST       = 7'd2;
    localparam logic [NCOUNT_W-1:0] NEIGHBOR_COUNT_RST = 5'd1;

    // item opcodes
    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_REF   = 1'b1;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] coord;
        logic               last_point;
    } item_word_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbor_index;
        logic [DIST_W-1:0]  distance;
        logic [RANK_W-1:0]  rank;
        logic               last;
    } result_word_t;

    // distance unit controls
    typedef struct packed {
        logic load_query;
        logic issue;
        logic square;
        logic accumulate;
        logic clear;
    } dist_ctl_t;

    // sorted list controls
    typedef struct packed {
        logic shift;
        logic place;
    } list_ctl_t;

endpackage

`default_nettype wire

>>> rtl/knn_dist_unit.sv
// ----------------------------------------------------------------------------
// knn_dist_unit: query store and squared distance accumulator
// One memory read, one multiplier and one saturating adder, reused for
// every coordinate of every point.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_dist_unit
    import knn_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dist_ctl_t              ctl,
    input  wire logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] addr,
    input  wire logic [COORD_BITS-1:0]  coord_in,
    output logic      [DIST_W-1:0]      acc_sum
);

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DIST_W{1'b1}});

    logic [COORD_BITS-1:0] query_mem [MAX_DIMS];
    logic [COORD_BITS-1:0] q_rd_reg;
    logic [COORD_BITS-1:0] coord_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIST_W-1:0]     partial_reg;
    logic [COORD_BITS-1:0] diff;
    logic [SUM_W-1:0]      sum;

    // query store: write on load, registered read on issue
    always_ff @(posedge clk)
    begin
        if (ctl.load_query)
        begin
            query_mem[addr] <= coord_in;
        end
        if (ctl.issue)
        begin
            q_rd_reg  <= query_mem[addr];
            coord_reg <= coord_in;
        end
    end

    // absolute difference, squared into a register
    always_comb
    begin
        diff = (coord_reg >= q_rd_reg) ? (coord_reg - q_rd_reg) : (q_rd_reg - coord_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.square)
        begin
            sq_reg <= diff * diff;
        end
    end

    // saturating accumulate
    always_comb
    begin
        sum     = SUM_W'(partial_reg) + SUM_W'(sq_reg);
        acc_sum = (sum > DIST_MAX) ? DIST_W'(DIST_MAX) : sum[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else if (ctl.clear)
        begin
            partial_reg <= '0;
        end
        else if (ctl.accumulate)
        begin
            partial_reg <= acc_sum;
        end
    end

endmodule

`default_nettype wire

>>> rtl/knn_topk_list.sv
// ----------------------------------------------------------------------------
// knn_topk_list: sorted list of the best distances and point indices
// One read port and one write port; insertion walks it one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_topk_list
    import knn_pkg::*;
#(
    parameter int MAX_K      = DEF_MAX_K,
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  wire logic                  clk,
    input  wire list_ctl_t             ctl,
    input  wire logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] wr_ptr,
    input  wire logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] rd_ptr,
    input  wire logic [DIST_W-1:0]     cand_dist,
    input  wire logic [$clog2(MAX_POINTS)-1:0] cand_idx,
    output logic      [DIST_W-1:0]     rd_dist,
    output logic      [$clog2(MAX_POINTS)-1:0] rd_idx,
    output logic                       rd_gt_cand,
    output logic                       cand_lt_rd
);

    localparam int PT_W = $clog2(MAX_POINTS);

    logic [DIST_W-1:0] dist_arr [MAX_K];
    logic [PT_W-1:0]   idx_arr  [MAX_K];

    // read port and both comparators
    always_comb
    begin
        rd_dist    = dist_arr[rd_ptr];
        rd_idx     = idx_arr[rd_ptr];
        rd_gt_cand = rd_dist > cand_dist;
        cand_lt_rd = cand_dist < rd_dist;
    end

    // write port: move an entry up one slot, or drop the candidate in
    always_ff @(posedge clk)
    begin
        if (ctl.place)
        begin
            dist_arr[wr_ptr] <= cand_dist;
            idx_arr[wr_ptr]  <= cand_idx;
        end
        else if (ctl.shift)
        begin
            dist_arr[wr_ptr] <= rd_dist;
            idx_arr[wr_ptr]  <= rd_idx;
        end
    end

endmodule

`default_nettype wire

>>> rtl/knn_topk_search.sv
// ----------------------------------------------------------------------------
// knn_topk_search: brute-force k-nearest-neighbor search for one query
// Sequencer, counters, configuration registers and result register.
// ----------------------------------------------------------------------------
// Load the query with op 0 words, one coordinate each (this also restarts
// the search), then stream reference points with op 1 words, one coordinate
// each, last_point set on the final point. A query word is stored in the query memory; a
// reference word passes through the query memory read, the square in the
// single multiplier and the saturating accumulate. The word that completes
// a point adds a check step and then an insertion, in which the comparators
// walk the sorted list an entry a cycle. After the last point up to k
// nearest neighbors come out in ascending distance, one per cycle when the
// result side does not stall. The block holds item_stall high while busy.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_topk_search
    import knn_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_K      = DEF_MAX_K,
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_word_t            item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_word_t               result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DC_W  = $clog2(MAX_DIMS + 1);
    localparam int KI_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KP_W  = $clog2(MAX_K + 1);
    localparam int PT_W  = $clog2(MAX_POINTS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQR    = 3'd1;
    localparam logic [2:0] S_ACC    = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_REPORT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [DIM_W-1:0]      dim_ctr_reg, dim_ctr_next;
    logic [PT_W-1:0]       point_ctr_reg, point_ctr_next;
    logic [KP_W-1:0]       fill_reg, fill_next;
    logic [KP_W-1:0]       ptr_reg, ptr_next;
    logic [DIST_W-1:0]     cand_dist_reg, cand_dist_next;
    logic [PT_W-1:0]       cand_idx_reg, cand_idx_next;
    logic                  lastp_reg, lastp_next;
    logic [NDIMS_W-1:0]    num_dims_reg;
    logic [NCOUNT_W-1:0]   neighbor_count_reg;
    logic                  out_valid_reg, out_valid_next;
    result_word_t          out_word_reg, out_word_next;

    logic [DC_W-1:0]       eff_dims;
    logic [KP_W-1:0]       eff_k;
    logic [DC_W-1:0]       dim_inc;
    logic                  point_done;
    logic                  item_take;
    logic                  out_free;
    logic                  rep_last;
    logic [KP_W-1:0]       fill_clamped;
    logic [KP_W-1:0]       rd_sel;

    dist_ctl_t             dctl;
    list_ctl_t             lctl;
    logic [DIST_W-1:0]     acc_sum;
    logic [DIST_W-1:0]     rd_dist;
    logic [PT_W-1:0]       rd_idx;
    logic                  rd_gt_cand;
    logic                  cand_lt_rd;

    // effective register values, out-of-range codes clamped
    always_comb
    begin
        if (num_dims_reg == '0)
        begin
            eff_dims = DC_W'(1);
        end
        else if (32'(num_dims_reg) > MAX_DIMS)
        begin
            eff_dims = DC_W'(MAX_DIMS);
        end
        else
        begin
            eff_dims = DC_W'(num_dims_reg);
        end

        if (neighbor_count_reg == '0)
        begin
            eff_k = KP_W'(1);
        end
        else if (32'(neighbor_count_reg) > MAX_K)
        begin
            eff_k = KP_W'(MAX_K);
        end
        else
        begin
            eff_k = KP_W'(neighbor_count_reg);
        end
    end

    assign dim_inc      = DC_W'(dim_ctr_reg) + DC_W'(1);
    assign point_done   = dim_inc >= eff_dims;
    assign item_take    = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign fill_clamped = (fill_reg > eff_k) ? eff_k : fill_reg;
    assign rep_last     = (ptr_reg + KP_W'(1)) == fill_reg;

    assign item_stall   = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // list read address
    always_comb
    begin
        unique case (state_reg)
            S_CHECK:  rd_sel = eff_k - KP_W'(1);
            S_SCAN:   rd_sel = ptr_reg - KP_W'(1);
            default:  rd_sel = ptr_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        dim_ctr_next   = dim_ctr_reg;
        point_ctr_next = point_ctr_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        cand_dist_next = cand_dist_reg;
        cand_idx_next  = cand_idx_reg;
        lastp_next     = lastp_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next  = out_word_reg;
        dctl           = '0;
        lctl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_take)
                begin
                    if (item.op == OP_QUERY)
                    begin
                        dctl.load_query = 1'b1;
                        dctl.clear      = 1'b1;
                        dim_ctr_next    = point_done ? '0 : DIM_W'(dim_inc);
                        point_ctr_next  = '0;
                        fill_next       = '0;
                    end
                    else
                    begin
                        dctl.issue = 1'b1;
                        lastp_next = item.last_point;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                dctl.square = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                if (point_done)
                begin
                    dctl.clear     = 1'b1;
                    cand_dist_next = acc_sum;
                    cand_idx_next  = point_ctr_reg;
                    dim_ctr_next   = '0;
                    point_ctr_next = (point_ctr_reg == PT_W'(MAX_POINTS - 1)) ?
                                     '0 : point_ctr_reg + PT_W'(1);
                    fill_next      = fill_clamped;
                    state_next     = S_CHECK;
                end
                else
                begin
                    dctl.accumulate = 1'b1;
                    dim_ctr_next    = DIM_W'(dim_inc);
                    state_next      = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (fill_reg != eff_k)
                begin
                    ptr_next   = fill_reg;
                    state_next = S_SCAN;
                end
                else if (cand_lt_rd)
                begin
                    // full list: evict the worst entry
                    fill_next  = eff_k - KP_W'(1);
                    ptr_next   = eff_k - KP_W'(1);
                    state_next = S_SCAN;
                end
                else
                begin
                    ptr_next   = '0;
                    state_next = lastp_reg ? S_REPORT : S_IDLE;
                end
            end
            S_SCAN:
            begin
                // move larger entries up, ties stay ahead of the candidate
                if ((ptr_reg != '0) && rd_gt_cand)
                begin
                    lctl.shift = 1'b1;
                    ptr_next   = ptr_reg - KP_W'(1);
                end
                else
                begin
                    lctl.place = 1'b1;
                    fill_next  = fill_reg + KP_W'(1);
                    ptr_next   = '0;
                    state_next = lastp_reg ? S_REPORT : S_IDLE;
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.neighbor_index = INDEX_W'(rd_idx);
                    out_word_next.distance      = rd_dist;
                    out_word_next.rank          = RANK_W'(ptr_reg);
                    out_word_next.last          = rep_last;
                    ptr_next                    = ptr_reg + KP_W'(1);
                    if (rep_last)
                    begin
                        point_ctr_next = '0;
                        fill_next      = '0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            dim_ctr_reg        <= '0;
            point_ctr_reg      <= '0;
            fill_reg           <= '0;
            ptr_reg            <= '0;
            lastp_reg          <= 1'b0;
            out_valid_reg      <= 1'b0;
            num_dims_reg       <= NUM_DIMS_RST;
            neighbor_count_reg <= NEIGHBOR_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            dim_ctr_reg   <= dim_ctr_next;
            point_ctr_reg <= point_ctr_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            lastp_reg     <= lastp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NUM_DIMS:       num_dims_reg       <= NDIMS_W'(cfg_data);
                    REG_NEIGHBOR_COUNT: neighbor_count_reg <= NCOUNT_W'(cfg_data);
                    default:            num_dims_reg       <= num_dims_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cand_dist_reg <= cand_dist_next;
        cand_idx_reg  <= cand_idx_next;
        out_word_reg  <= out_word_next;
    end

    knn_dist_unit #(
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (dctl),
        .addr     (dim_ctr_reg),
        .coord_in (COORD_BITS'(item.coord)),
        .acc_sum  (acc_sum)
    );

    knn_topk_list #(
        .MAX_K      (MAX_K),
        .MAX_POINTS (MAX_POINTS)
    ) u_list (
        .clk        (clk),
        .ctl        (lctl),
        .wr_ptr     (ptr_reg[KI_W-1:0]),
        .rd_ptr     (rd_sel[KI_W-1:0]),
        .cand_dist  (cand_dist_reg),
        .cand_idx   (cand_idx_reg),
        .rd_dist    (rd_dist),
        .rd_idx     (rd_idx),
        .rd_gt_cand (rd_gt_cand),
        .cand_lt_rd (cand_lt_rd)
    );

    // checks
    a_ref_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && (item.op == OP_REF)) |=> (state_reg == S_SQR))
        else $error("reference word did not start the square step");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (fill_reg < eff_k))
        else $error("insertion started on a full list");

    a_report_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |-> ((fill_reg != '0) && (ptr_reg < fill_reg)))
        else $error("report pointer past the kept entries");

    a_dim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(dim_ctr_reg) < MAX_DIMS))
        else $error("dimension counter out of range");

endmodule

`default_nettype wire

>>> sim/tb_knn_topk_search.sv
// ----------------------------------------------------------------------------
// tb_knn_topk_search: self-checking testbench for the k-nearest-neighbor search
// Loads the query slots the run uses, walks a short directed plan (register
// extremes, single-neighbor distances, ties, evictions, query reload in the
// middle of a search), then runs random searches under eight register and
// flow-control settings. A local model of the search predicts each reported
// neighbor; every result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_knn_topk_search;
    import knn_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 4;
    localparam int LOADED_DIMS   = 8;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // one directed step: a register write or an input word
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_word_t            word;
        bit                    typed;
        result_word_t          want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_word_t            item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_word_t          result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // flow control and bookkeeping
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatch_count     = 0;
    int results_checked    = 0;
    int words_sent         = 0;
    int cycle_count        = 0;

    // register settings per random phase; flow mix 0 none, 1 sender, 2 receiver, 3 both
    int phase_dims [PHASES] = '{1, 3, 2, 0, 8, 4, 2, 1};
    int phase_k    [PHASES] = '{4, 16, 31, 0, 2, 7, 1, 16};
    int phase_flow [PHASES] = '{0, 1, 2, 3, 0, 2, 1, 3};

    // search model state
    logic [NDIMS_W-1:0]  cfg_num_dims       = NUM_DIMS_RST;
    logic [NCOUNT_W-1:0] cfg_neighbor_count = NEIGHBOR_COUNT_RST;
    logic [COORD_W-1:0]  query_coords [DEF_MAX_DIMS];
    int                  dim_pos    = 0;
    logic [INDEX_W-1:0]  point_pos  = '0;
    logic [DIST_W-1:0]   dist_acc   = '0;
    logic [DIST_W-1:0]   kept_dist  [DEF_MAX_K];
    logic [INDEX_W-1:0]  kept_index [DEF_MAX_K];
    int                  kept_count = 0;
    result_word_t        neighbor_report [DEF_MAX_K];

    result_word_t expected_neighbors [$];
    plan_row_t    directed_plan [$];

    knn_topk_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_neighbors.size());
            $display("tb_knn_topk_search failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < receiver_stall_pct);

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (expected_neighbors.size() == 0)
                report_mismatch("result word with nothing expected", result.neighbor_index, 0);
            else
            begin
                want = expected_neighbors.pop_front();
                if (result.neighbor_index !== want.neighbor_index)
                    report_mismatch("neighbor_index", result.neighbor_index, want.neighbor_index);
                if (result.distance !== want.distance)
                    report_mismatch("distance", result.distance, want.distance);
                if (result.rank !== want.rank)
                    report_mismatch("rank", result.rank, want.rank);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    // effective register values
    function automatic int eff_dims();
        if (cfg_num_dims == 0) return 1;
        if (cfg_num_dims > DEF_MAX_DIMS) return DEF_MAX_DIMS;
        return int'(cfg_num_dims);
    endfunction

    function automatic int eff_k();
        if (cfg_neighbor_count == 0) return 1;
        if (cfg_neighbor_count > DEF_MAX_K) return DEF_MAX_K;
        return int'(cfg_neighbor_count);
    endfunction

    function automatic void restart_search();
        point_pos  = '0;
        kept_count = 0;
        dist_acc   = '0;
    endfunction

    // sorted insert; equal distances stay behind the earlier point
    function automatic void keep_point(logic [DIST_W-1:0] d, logic [INDEX_W-1:0] idx);
        int k;
        int pos;
        k = eff_k();
        if (kept_count > k) kept_count = k;
        if (kept_count == k)
        begin
            if (!(d < kept_dist[k - 1])) return;
            kept_count = k - 1;
        end
        pos = kept_count;
        while (pos > 0 && kept_dist[pos - 1] > d) pos--;
        for (int i = kept_count; i > pos; i--)
        begin
            kept_dist[i]  = kept_dist[i - 1];
            kept_index[i] = kept_index[i - 1];
        end
        kept_dist[pos]  = d;
        kept_index[pos] = idx;
        kept_count++;
    endfunction

    // advance the search by one word; returns how many neighbors it reports
    function automatic int predict_neighbors(item_word_t w);
        int                 nd;
        int                 k;
        logic [COORD_W-1:0] q;
        logic [COORD_W-1:0] diff;
        logic [DIST_W:0]    sum;
        nd = eff_dims();
        k  = eff_k();
        if (w.op == OP_QUERY)
        begin
            if (dim_pos < DEF_MAX_DIMS) query_coords[dim_pos] = w.coord;
            dim_pos++;
            if (dim_pos >= nd) dim_pos = 0;
            restart_search();
            return 0;
        end
        q    = (dim_pos < DEF_MAX_DIMS) ? query_coords[dim_pos] : '0;
        diff = (w.coord >= q) ? w.coord - q : q - w.coord;
        sum  = dist_acc + diff * diff;
        dist_acc = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
        dim_pos++;
        if (dim_pos < nd) return 0;
        // point complete
        keep_point(dist_acc, point_pos);
        dist_acc  = '0;
        dim_pos   = 0;
        point_pos = point_pos + 1'b1;
        if (!w.last_point) return 0;
        if (kept_count > k) kept_count = k;
        for (int i = 0; i < kept_count; i++)
        begin
            neighbor_report[i].neighbor_index = kept_index[i];
            neighbor_report[i].distance       = kept_dist[i];
            neighbor_report[i].rank           = RANK_W'(i);
            neighbor_report[i].last           = (i + 1 == kept_count);
        end
        k = kept_count;
        restart_search();
        return k;
    endfunction

    // directed plan builders
    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row         = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_word(logic op, logic [COORD_W-1:0] coord, logic lastp);
        plan_row_t row;
        row                 = '{default: '0};
        row.word.op         = op;
        row.word.coord      = coord;
        row.word.last_point = lastp;
        directed_plan.push_back(row);
    endfunction

    // final point of a single-neighbor search, expected result written out
    function automatic void plan_typed(logic [COORD_W-1:0] coord, logic [DIST_W-1:0] want_dist);
        plan_row_t row;
        row                     = '{default: '0};
        row.word.op             = OP_REF;
        row.word.coord          = coord;
        row.word.last_point     = 1'b1;
        row.typed               = 1'b1;
        row.want.neighbor_index = '0;
        row.want.distance       = want_dist;
        row.want.rank           = '0;
        row.want.last           = 1'b1;
        directed_plan.push_back(row);
    endfunction

    // hold off input words until all expected results are out
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_neighbors.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_DIMS)
            cfg_num_dims = val;
        else
            cfg_neighbor_count = val[NCOUNT_W-1:0];
    endtask

    task automatic send_word(item_word_t w, bit typed, result_word_t want);
        int n;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        n = predict_neighbors(w);
        words_sent++;
        if (typed)
            expected_neighbors.push_back(want);
        else
            for (int i = 0; i < n; i++) expected_neighbors.push_back(neighbor_report[i]);
    endtask

    task automatic send_fields(logic op, logic [COORD_W-1:0] coord, logic lastp);
        item_word_t w;
        w.op         = op;
        w.coord      = coord;
        w.last_point = lastp;
        send_word(w, 1'b0, '0);
    endtask

    // clustered coordinates give near and equal distances
    function automatic logic [COORD_W-1:0] pick_coord(bit near, logic [COORD_W-1:0] base);
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? {COORD_W{1'b1}} : {COORD_W{1'b0}};
        if (near)
            return base + COORD_W'($urandom_range(3));
        return COORD_W'($urandom);
    endfunction

    // one search: optional query load, then npts whole points
    task automatic stream_search(bit load_query, int npts, bit close_search);
        int                 nd;
        bit                 near;
        bit                 done_point;
        logic [COORD_W-1:0] base;
        nd   = eff_dims();
        near = 1'($urandom_range(1));
        base = COORD_W'($urandom);
        if (load_query)
            repeat (nd) send_fields(OP_QUERY, pick_coord(near, base), 1'($urandom_range(1)));
        for (int p = 0; p < npts; p++)
        begin
            done_point = 1'b0;
            while (!done_point)
            begin
                done_point = (dim_pos + 1 >= nd);
                // last_point only counts on the word that completes a point
                send_fields(OP_REF, pick_coord(near, base),
                            done_point ? (close_search && p == npts - 1)
                                       : 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin : stimulus
        int  nd;
        int  start;
        bit  paused_once;
        paused_once = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the query slots the run uses so no point reads an unloaded coordinate
        write_reg(REG_NUM_DIMS, 7'(LOADED_DIMS));
        repeat (LOADED_DIMS) send_fields(OP_QUERY, COORD_W'($urandom), 1'($urandom_range(1)));

        // single neighbor, one dimension: zero and full-scale distances
        plan_reg(REG_NUM_DIMS, 7'd1);
        plan_reg(REG_NEIGHBOR_COUNT, 7'd1);
        plan_word(OP_QUERY, 16'd0, 1'b1);
        plan_typed(16'd0, 38'd0);
        plan_typed(16'hFFFF, 38'd4294836225);
        plan_word(OP_QUERY, 16'hFFFF, 1'b0);
        plan_typed(16'd0, 38'd4294836225);
        // neighbor_count zero acts as one
        plan_reg(REG_NEIGHBOR_COUNT, 7'd0);
        plan_typed(16'hFFFF, 38'd0);
        // two dimensions, fewer points than k, last_point mid-point ignored
        plan_reg(REG_NUM_DIMS, 7'd2);
        plan_reg(REG_NEIGHBOR_COUNT, 7'd3);
        plan_word(OP_QUERY, 16'd100, 1'b0);
        plan_word(OP_QUERY, 16'd200, 1'b0);
        plan_word(OP_REF, 16'd100, 1'b1);
        plan_word(OP_REF, 16'd200, 1'b0);
        plan_word(OP_REF, 16'd101, 1'b0);
        plan_word(OP_REF, 16'd202, 1'b1);
        // tie keeps the earlier point, a closer point evicts the worst
        plan_reg(REG_NEIGHBOR_COUNT, 7'd2);
        plan_word(OP_REF, 16'd100, 1'b0);
        plan_word(OP_REF, 16'd201, 1'b0);
        plan_word(OP_REF, 16'd99, 1'b0);
        plan_word(OP_REF, 16'd200, 1'b0);
        plan_word(OP_REF, 16'd100, 1'b0);
        plan_word(OP_REF, 16'd200, 1'b1);
        // query reload in the middle of a search restarts it
        plan_word(OP_REF, 16'd0, 1'b0);
        plan_word(OP_REF, 16'd0, 1'b0);
        plan_word(OP_QUERY, 16'd7, 1'b0);
        plan_word(OP_QUERY, 16'd9, 1'b0);
        plan_word(OP_REF, 16'd7, 1'b0);
        plan_word(OP_REF, 16'd9, 1'b1);
        // out-of-range register values clamp
        plan_reg(REG_NEIGHBOR_COUNT, 7'd31);
        plan_reg(REG_NUM_DIMS, 7'd0);
        plan_word(OP_REF, 16'hFFFF, 1'b1);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_reg)
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            else
                send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
        end

        // random searches; each phase ends mid-search so the next settings land on it
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(REG_NUM_DIMS, CFG_DATA_W'(phase_dims[ph]));
            write_reg(REG_NEIGHBOR_COUNT, CFG_DATA_W'(phase_k[ph]));
            sender_idle_pct    = (phase_flow[ph] == 1) ? 87 : (phase_flow[ph] == 3) ? 19 : 0;
            receiver_stall_pct = (phase_flow[ph] == 2) ? 87 : (phase_flow[ph] == 3) ? 19 : 0;
            nd    = eff_dims();
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 12)
                    send_fields(1'($urandom_range(1)), COORD_W'($urandom), 1'($urandom_range(1)));
                else
                begin
                    stream_search((nd <= 8) && $urandom_range(1),
                                  (nd > 8) ? 1 : $urandom_range(1, eff_k() + 3), 1'b1);
                    if (!paused_once || $urandom_range(3) == 0)
                    begin
                        wait_drained();
                        paused_once = 1'b1;
                    end
                end
            end
            stream_search(1'b0, $urandom_range(2), 1'b0);
            repeat ($urandom_range((nd > 6) ? 5 : nd - 1))
                send_fields(OP_REF, COORD_W'($urandom), 1'($urandom_range(1)));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d input words and %0d neighbor results", words_sent, results_checked);
        $display("num_dims 0..8, neighbor_count 0..31, four idle/stall mixes");
        if (mismatch_count == 0)
            $display("tb_knn_topk_search passed");
        else
            $display("tb_knn_topk_search failed");
        $finish;
    end

endmodule

`default_nettype wire
